@@ src/linear_blend_vertex_skinning_unit_defines.svh @@
// Assertion macros for the linear blend skinning unit.
// Depends on nothing; included by the checker.
`ifndef LINEAR_BLEND_VERTEX_SKINNING_UNIT_DEFINES_SVH
`define LINEAR_BLEND_VERTEX_SKINNING_UNIT_DEFINES_SVH
// same-cycle implication, sampled on clk, off during reset
`define LBVS_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);
// next-cycle implication, sampled on clk, off during reset
`define LBVS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);
`endif

@@ src/lbvs_pkg.sv @@
// Shared types, codes and the saturation helper of the skinning unit.
// Depends on nothing.
`timescale 1ns / 1ps
package lbvs_pkg;
  localparam int unsigned ELEMS = 12;

  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_BAD_JOINT = 2'd1;
  localparam logic [1:0] ST_BAD_ADDR  = 2'd2;

  localparam logic [1:0] K_ZERO = 2'd0;
  localparam logic [1:0] K_PASS = 2'd1;
  localparam logic [1:0] K_SKIN = 2'd2;

  typedef logic signed [31:0] q16_t;

  typedef struct packed {
    logic [1:0] kind;
    logic [1:0] status;
  } ctrl_t;

  function automatic q16_t sat32(input logic signed [65:0] v);
    q16_t res;
    if (v > 66'sd2147483647) begin
      res = 32'sh7fffffff;
    end else if (v < -66'sd2147483648) begin
      res = 32'sh80000000;
    end else begin
      res = v[31:0];
    end
    return res;
  endfunction
endpackage

@@ src/lbvs_row.sv @@
// One output row: s0*x + s1*y + s2*z + s3, rounded half up and saturated.
// Depends on lbvs_pkg. Two register stages, advanced by adv.
`timescale 1ns / 1ps
module lbvs_row
  import lbvs_pkg::*;
(
  input  logic clk,
  input  logic adv,
  input  q16_t s_in [4],
  input  q16_t pos_in [3],
  output q16_t res_r
);
  logic signed [63:0] prod_r [3];
  q16_t trans_r;
  logic signed [65:0] sum_nxt;
  logic signed [65:0] shr_nxt;

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int c = 0; c < 3; c++) begin
        prod_r[c] <= s_in[c] * pos_in[c];
      end
      trans_r <= s_in[3];
    end
  end

  always_comb begin
    sum_nxt = 66'(prod_r[0]) + 66'(prod_r[1]) + 66'(prod_r[2])
            + (66'(trans_r) <<< 16) + 66'sd32768;
    shr_nxt = sum_nxt >>> 16;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      res_r <= sat32(shr_nxt);
    end
  end
endmodule

@@ src/linear_blend_vertex_skinning_unit.sv @@
// Top level of the four-influence linear blend skinning unit.
// Depends on lbvs_pkg and lbvs_row.
//
// Input channel (in_valid / in_stall) takes one beat per item: op 0 loads
// one Q16.16 matrix element at load_address, op 1 skins one vertex with four
// joint indices, four Q1.16 weights and a Q16.16 position. Every beat gives
// exactly one result beat (out_x/y/z, out_status) in order.
// The user must write cfg_joint_count via cfg_valid / cfg_ready only while
// idle; the block does not enforce it. cfg_ready is always high. Zero passes
// positions through unchanged. Stages: table read, weighted products, blend
// round, row products, row sum; one beat enters every cycle unless in_stall
// is high. The matrix table is held as 48 banks (4 influences by 12
// elements) of MAX_JOINTS words each, so all 48 reads of a vertex happen
// together; a load writes all 4 copies. Reset clears the joint count and the
// valid bits; table contents are undefined until loaded, with no clearing
// pass. When out_stall holds a valid result, the whole pipeline holds and
// in_stall is raised; nothing is lost or repeated.
`timescale 1ns / 1ps
module linear_blend_vertex_skinning_unit
  import lbvs_pkg::*;
#(
  parameter int MAX_JOINTS = 64
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic               in_op,
  input  logic [31:0]        in_joint_indices,
  input  logic [16:0]        in_weight_0,
  input  logic [16:0]        in_weight_1,
  input  logic [16:0]        in_weight_2,
  input  logic [16:0]        in_weight_3,
  input  logic signed [31:0] in_pos_x,
  input  logic signed [31:0] in_pos_y,
  input  logic signed [31:0] in_pos_z,
  input  logic [9:0]         in_load_address,
  input  logic signed [31:0] in_load_value,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [31:0] out_x,
  output logic signed [31:0] out_y,
  output logic signed [31:0] out_z,
  output logic [1:0]         out_status,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [6:0]         cfg_joint_count
);
  localparam int JW = (MAX_JOINTS > 1) ? $clog2(MAX_JOINTS) : 1;
  localparam logic [8:0] MAXJ = 9'(MAX_JOINTS);

  logic       adv;
  logic       acc;
  logic [6:0] joint_count_r;
  logic [8:0] cnt;
  logic [7:0] jidx [4];
  logic [16:0] win [4];
  logic [7:0] wr_joint;
  logic       wr_en;
  logic       bad_joint;
  ctrl_t      ctrl_nxt;

  logic  v1_r, v2_r, v3_r, v4_r, v5_r;
  ctrl_t c1_r, c2_r, c3_r, c4_r, c5_r;
  q16_t  p1_r [3];
  q16_t  p2_r [3];
  q16_t  p3_r [3];
  q16_t  p4_r [3];
  q16_t  p5_r [3];
  logic [16:0] w1_r [4];
  q16_t  rd_r [4][ELEMS];
  logic signed [49:0] prod2_r [4][ELEMS];
  q16_t  s3_r [ELEMS];
  q16_t  row_res [3];

  assign adv      = !(v5_r && out_stall);
  assign in_stall = !adv;
  assign acc      = in_valid && adv;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      joint_count_r <= '0;
    end else if (cfg_valid && cfg_ready) begin
      joint_count_r <= cfg_joint_count;
    end
  end

  assign win[0] = in_weight_0;
  assign win[1] = in_weight_1;
  assign win[2] = in_weight_2;
  assign win[3] = in_weight_3;

  always_comb begin
    cnt = ({2'b00, joint_count_r} > MAXJ) ? MAXJ : {2'b00, joint_count_r};
    bad_joint = 1'b0;
    for (int i = 0; i < 4; i++) begin
      jidx[i] = in_joint_indices[8*i +: 8];
      if ({1'b0, jidx[i]} >= cnt) begin
        bad_joint = 1'b1;
      end
    end
    wr_joint = {2'b00, in_load_address[9:4]};
    wr_en = 1'b0;
    ctrl_nxt.kind   = K_ZERO;
    ctrl_nxt.status = ST_OK;
    if (!in_op) begin
      if ((in_load_address[3:0] >= 4'(ELEMS)) || ({1'b0, wr_joint} >= MAXJ)) begin
        ctrl_nxt.status = ST_BAD_ADDR;
      end else begin
        wr_en = acc;
      end
    end else if (joint_count_r == '0) begin
      ctrl_nxt.kind = K_PASS;
    end else if (bad_joint) begin
      ctrl_nxt.status = ST_BAD_JOINT;
    end else begin
      ctrl_nxt.kind = K_SKIN;
    end
  end

  for (genvar gi = 0; gi < 4; gi++) begin : g_infl
    for (genvar ge = 0; ge < ELEMS; ge++) begin : g_elem
      logic [31:0] bank [MAX_JOINTS];
      always_ff @(posedge clk) begin
        if (wr_en && (in_load_address[3:0] == 4'(ge))) begin
          bank[wr_joint[JW-1:0]] <= in_load_value;
        end
        if (adv) begin
          rd_r[gi][ge] <= bank[jidx[gi][JW-1:0]];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
      v5_r <= 1'b0;
    end else if (adv) begin
      v1_r <= acc;
      v2_r <= v1_r;
      v3_r <= v2_r;
      v4_r <= v3_r;
      v5_r <= v4_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      c1_r <= ctrl_nxt;
      p1_r[0] <= in_pos_x;
      p1_r[1] <= in_pos_y;
      p1_r[2] <= in_pos_z;
      w1_r <= win;
      c2_r <= c1_r;
      p2_r <= p1_r;
      c3_r <= c2_r;
      p3_r <= p2_r;
      c4_r <= c3_r;
      p4_r <= p3_r;
      c5_r <= c4_r;
      p5_r <= p4_r;
      for (int i = 0; i < 4; i++) begin
        for (int e = 0; e < ELEMS; e++) begin
          prod2_r[i][e] <= $signed({1'b0, w1_r[i]}) * rd_r[i][e];
        end
      end
    end
  end

  logic signed [51:0] bsum [ELEMS];
  logic signed [51:0] bshr [ELEMS];

  always_comb begin
    for (int e = 0; e < ELEMS; e++) begin
      bsum[e] = 52'(prod2_r[0][e]) + 52'(prod2_r[1][e]) + 52'(prod2_r[2][e])
              + 52'(prod2_r[3][e]) + 52'sd32768;
      bshr[e] = bsum[e] >>> 16;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int e = 0; e < ELEMS; e++) begin
        s3_r[e] <= sat32(66'(bshr[e]));
      end
    end
  end

  for (genvar gr = 0; gr < 3; gr++) begin : g_row
    lbvs_row u_row (
      .clk    (clk),
      .adv    (adv),
      .s_in   (s3_r[gr*4 +: 4]),
      .pos_in (p3_r),
      .res_r  (row_res[gr])
    );
  end

  assign out_valid  = v5_r;
  assign out_status = c5_r.status;

  always_comb begin
    case (c5_r.kind)
      K_PASS: begin
        out_x = p5_r[0];
        out_y = p5_r[1];
        out_z = p5_r[2];
      end
      K_SKIN: begin
        out_x = row_res[0];
        out_y = row_res[1];
        out_z = row_res[2];
      end
      default: begin
        out_x = '0;
        out_y = '0;
        out_z = '0;
      end
    endcase
  end
endmodule

@@ src/lbvs_checker.sv @@
// Port-level checks of the skinning unit, bound to the top level.
// Depends on lbvs_pkg and linear_blend_vertex_skinning_unit_defines.svh.
`timescale 1ns / 1ps
`include "linear_blend_vertex_skinning_unit_defines.svh"
module lbvs_checker
  import lbvs_pkg::*;
(
  input logic        clk,
  input logic        rst_n,
  input logic        in_stall,
  input logic        out_valid,
  input logic        out_stall,
  input logic [31:0] out_x,
  input logic [31:0] out_y,
  input logic [31:0] out_z,
  input logic [1:0]  out_status
);
  `LBVS_ASSERT_NEXT(a_hold_valid, out_valid && out_stall, out_valid, "result beat dropped")
  `LBVS_ASSERT_NEXT(a_hold_x, out_valid && out_stall, $stable(out_x), "stalled beat changed")
  `LBVS_ASSERT_NOW(a_err_zero, out_valid && (out_status == ST_BAD_JOINT || out_status == ST_BAD_ADDR), out_x == 0 && out_y == 0 && out_z == 0, "error beat not zero")
  `LBVS_ASSERT_NOW(a_backpressure, out_valid && out_stall, in_stall, "input taken while output held")
endmodule

bind linear_blend_vertex_skinning_unit lbvs_checker u_lbvs_checker (.*);
